[src/lrut_pkg.sv]
// ----------------------------------------------------------------------------
// lrut_pkg
// Shared types and constants of the LRU tag store: request and response
// payloads, the tag key, and the command and status bundles that run between
// the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lrut_pkg;

    // Default geometry, used as the defaults of the top level parameters
    localparam int DEF_ENTRIES    = 12;
    localparam int DEF_STAMP_BITS = 32;

    // Field widths of the payloads
    localparam int SRC_W     = 4;
    localparam int CODE_W    = 10;
    localparam int VAR_W     = 8;
    localparam int IDX_OUT_W = 4;
    localparam int KEY_W     = SRC_W + CODE_W + VAR_W;

    // Operation codes
    localparam logic OP_LOOKUP  = 1'b0;
    localparam logic OP_INSTALL = 1'b1;

    // Request transaction payload
    typedef struct packed {
        logic              opcode;
        logic [SRC_W-1:0]  source_id;
        logic [CODE_W-1:0] item_code;
        logic [VAR_W-1:0]  item_variant;
    } req_t;

    // Response transaction payload
    typedef struct packed {
        logic                 hit;
        logic [IDX_OUT_W-1:0] entry_index;
        logic                 evicted;
    } rsp_t;

    // Tag key held in each entry
    typedef struct packed {
        logic [SRC_W-1:0]  source_id;
        logic [CODE_W-1:0] item_code;
        logic [VAR_W-1:0]  item_variant;
    } key_t;

    // Controller to datapath commands
    typedef struct packed {
        logic start;   // latch request, clear scan state
        logic scan;    // read next entry, compare previous one
        logic commit;  // write back entry, load response register
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic done;      // scan result is final
        logic out_free;  // response register can take a new result
    } ctrl_sts_t;

endpackage

`default_nettype wire

[src/lrut_chan_if.sv]
// ----------------------------------------------------------------------------
// lrut_chan_if
// Valid/ready channel carrying one payload of type T per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface lrut_chan_if #(
    parameter type T = logic
);

    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );

endinterface

`default_nettype wire

[src/lrut_ctrl.sv]
// ----------------------------------------------------------------------------
// lrut_ctrl
// Sequencer of the tag store: takes a request, runs the entry scan until the
// datapath reports a final answer, then commits once the response register
// has room.
// ----------------------------------------------------------------------------
`default_nettype none

module lrut_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  lrut_pkg::ctrl_sts_t  sts,
    output lrut_pkg::ctrl_cmd_t  cmd
);

    import lrut_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    // Next state and command decode
    always_comb
    begin
        state_next = state_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.done)
                begin
                    state_next = S_COMMIT;
                end
            end
            S_COMMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/lrut_dp.sv]
// ----------------------------------------------------------------------------
// lrut_dp
// Datapath of the tag store: entry memory with registered read, valid bits,
// one-entry-per-cycle compare stage tracking the hit or free entry and the
// oldest stamp, use counter, and the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module lrut_dp #(
    parameter int ENTRIES    = lrut_pkg::DEF_ENTRIES,
    parameter int STAMP_BITS = lrut_pkg::DEF_STAMP_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lrut_pkg::ctrl_cmd_t  cmd,
    output lrut_pkg::ctrl_sts_t  sts,
    input  lrut_pkg::req_t       req_data,
    input  logic                 rsp_ready,
    output logic                 rsp_valid,
    output lrut_pkg::rsp_t       rsp_data
);

    import lrut_pkg::*;

    localparam int IDX_W  = $clog2(ENTRIES);
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = KEY_W + STAMP_BITS;
    localparam int EXT_W  = (IDX_W > IDX_OUT_W) ? IDX_W : IDX_OUT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);
    localparam logic [CNT_W-1:0] END_ADDR = CNT_W'(ENTRIES);

    // Entry memory: key in the upper bits, use stamp in the lower bits
    logic [WORD_W-1:0] mem [ENTRIES];

    logic                  op_reg;
    key_t                  key_reg;
    logic [CNT_W-1:0]      addr_reg;
    logic [CNT_W-1:0]      addr_next;
    logic [WORD_W-1:0]     rd_word_reg;
    logic [IDX_W-1:0]      cmp_idx_reg;
    logic                  cmp_vld_reg;
    logic                  cmp_vld_next;
    logic                  found_reg;
    logic                  found_next;
    logic [IDX_W-1:0]      found_idx_reg;
    logic                  best_vld_reg;
    logic                  best_vld_next;
    logic [IDX_W-1:0]      best_idx_reg;
    logic [STAMP_BITS-1:0] best_stamp_reg;
    logic [ENTRIES-1:0]    valid_reg;
    logic [ENTRIES-1:0]    valid_next;
    logic [STAMP_BITS-1:0] counter_reg;
    logic [STAMP_BITS-1:0] counter_next;
    logic                  rsp_valid_reg;
    logic                  rsp_valid_next;
    rsp_t                  rsp_data_reg;
    rsp_t                  rsp_data_next;

    logic [IDX_W-1:0]      addr_idx;
    logic                  issue;
    key_t                  rd_key;
    logic [STAMP_BITS-1:0] rd_stamp;
    logic                  cmp_fire;
    logic                  entry_ok;
    logic                  take_found;
    logic                  take_best;
    logic                  is_install;
    logic [IDX_W-1:0]      victim_idx;
    logic                  do_write;
    logic [STAMP_BITS-1:0] stamp_new;
    logic [EXT_W-1:0]      idx_ext;

    // Scan address and read issue
    assign addr_idx = addr_reg[IDX_W-1:0];
    assign issue    = cmd.scan && (addr_reg != END_ADDR);

    // Compare stage on the word read in the previous cycle
    assign rd_key     = key_t'(rd_word_reg[WORD_W-1 -: KEY_W]);
    assign rd_stamp   = rd_word_reg[STAMP_BITS-1:0];
    assign cmp_fire   = cmd.scan && cmp_vld_reg && !found_reg;
    assign entry_ok   = valid_reg[cmp_idx_reg];
    assign is_install = (op_reg == OP_INSTALL);

    always_comb
    begin
        if (is_install)
        begin
            take_found = cmp_fire && !entry_ok;
        end
        else
        begin
            take_found = cmp_fire && entry_ok && (rd_key == key_reg);
        end
    end

    assign take_best = cmp_fire && is_install && entry_ok &&
                       (!best_vld_reg || (rd_stamp < best_stamp_reg));

    // Commit: victim is the hit or free entry, else the oldest one
    assign victim_idx = found_reg ? found_idx_reg : best_idx_reg;
    assign do_write   = cmd.commit && (is_install || found_reg);
    assign stamp_new  = counter_reg + STAMP_BITS'(1);
    assign idx_ext    = do_write ? EXT_W'(victim_idx) : '0;

    // Status to the controller
    assign sts.done     = found_reg || (cmp_vld_reg && (cmp_idx_reg == LAST_IDX));
    assign sts.out_free = !rsp_valid_reg || rsp_ready;

    // Next values of control state
    always_comb
    begin
        addr_next      = addr_reg;
        cmp_vld_next   = cmp_vld_reg;
        found_next     = found_reg;
        best_vld_next  = best_vld_reg;
        valid_next     = valid_reg;
        counter_next   = counter_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        if (cmd.start)
        begin
            addr_next     = '0;
            cmp_vld_next  = 1'b0;
            found_next    = 1'b0;
            best_vld_next = 1'b0;
        end
        else if (cmd.scan)
        begin
            cmp_vld_next = issue;
            if (issue)
            begin
                addr_next = addr_reg + CNT_W'(1);
            end
            if (take_found)
            begin
                found_next = 1'b1;
            end
            if (take_best)
            begin
                best_vld_next = 1'b1;
            end
        end
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (cmd.commit)
        begin
            rsp_valid_next            = 1'b1;
            rsp_data_next.hit         = !is_install && found_reg;
            rsp_data_next.entry_index = idx_ext[IDX_OUT_W-1:0];
            rsp_data_next.evicted     = is_install && !found_reg;
            if (do_write)
            begin
                counter_next = stamp_new;
            end
            if (is_install)
            begin
                valid_next[victim_idx] = 1'b1;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            cmp_vld_reg   <= 1'b0;
            found_reg     <= 1'b0;
            best_vld_reg  <= 1'b0;
            valid_reg     <= '0;
            counter_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            addr_reg      <= addr_next;
            cmp_vld_reg   <= cmp_vld_next;
            found_reg     <= found_next;
            best_vld_reg  <= best_vld_next;
            valid_reg     <= valid_next;
            counter_reg   <= counter_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
        if (cmd.start)
        begin
            op_reg                <= req_data.opcode;
            key_reg.source_id     <= req_data.source_id;
            key_reg.item_code     <= req_data.item_code;
            key_reg.item_variant  <= req_data.item_variant;
        end
        if (issue)
        begin
            cmp_idx_reg <= addr_idx;
        end
        if (take_found)
        begin
            found_idx_reg <= cmp_idx_reg;
        end
        if (take_best)
        begin
            best_idx_reg   <= cmp_idx_reg;
            best_stamp_reg <= rd_stamp;
        end
    end

    // Entry memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            mem[victim_idx] <= {key_reg, stamp_new};
        end
        if (issue)
        begin
            rd_word_reg <= mem[addr_idx];
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

`ifndef ASSERT_OFF
    // A commit never overwrites a response still waiting
    a_commit_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> (!rsp_valid_reg || rsp_ready))
        else $error("commit while response register full");

    // Valid bits are only ever set
    a_valid_grow: assert property (@(posedge clk) disable iff (!rst_n)
        ($countones(valid_reg) >= $countones($past(valid_reg))))
        else $error("valid entry lost");

    // The use counter moves only on a committed write
    a_counter_commit: assert property (@(posedge clk) disable iff (!rst_n)
        (counter_reg != $past(counter_reg)) |-> $past(do_write))
        else $error("use counter moved without a write");

    // Eviction only happens when every entry is valid
    a_evict_full: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && is_install && !found_reg) |-> (&valid_reg))
        else $error("eviction with a free entry present");
`endif

endmodule

`default_nettype wire

[src/lru_tag_store_lookup_install_top.sv]
// ----------------------------------------------------------------------------
// lru_tag_store_lookup_install_top
// Fully associative tag store with least-recently-used replacement: lookup
// restamps a matching entry, install fills the first free or the oldest entry.
//
//   Channel | Dir | Payload | Transaction
//   --------+-----+---------+-----------------------------------------------
//   req     | in  | req_t   | one lookup or install request
//   rsp     | out | rsp_t   | hit, entry_index, evicted for each request
//
// A lookup miss or an install that evicts scans every entry before the commit;
// a lookup hit or an install into a free entry stops at that entry. The next
// request is taken in the cycle after the commit. The scan time is set by the
// entry memory, which is read one entry per cycle at a single port and
// compared in the next.
// The response sits in an output register; a new request is taken while it
// waits, and only the commit stalls until the response has been taken.
// Reset clears valid bits, use counter and handshake state.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_tag_store_lookup_install_top #(
    parameter int ENTRIES    = lrut_pkg::DEF_ENTRIES,
    parameter int STAMP_BITS = lrut_pkg::DEF_STAMP_BITS
) (
    input  logic        clk,
    input  logic        rst_n,
    lrut_chan_if.sink   req,
    lrut_chan_if.source rsp
);

    import lrut_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic      in_ready;

    // Sequencer
    lrut_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // Entry store and compare logic
    lrut_dp #(
        .ENTRIES    (ENTRIES),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req_data  (req.data),
        .rsp_ready (rsp.ready),
        .rsp_valid (rsp.valid),
        .rsp_data  (rsp.data)
    );

    assign req.ready = in_ready;

endmodule

`default_nettype wire
